[rtl/fbd_pkg.sv]
// Shared types and constants for the mono framebuffer draw engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package fbd_pkg;

    localparam int STORE_BYTES = 16384;
    localparam int ADDR_BITS   = $clog2(STORE_BYTES);
    localparam int COORD_BITS  = 11;
    localparam int PITCH_BITS  = 12;
    localparam int PITCH_RESET = 40;
    // Linear byte address: y*pitch + x/8 plus a bar run of up to 2^COORD_BITS - 1 lines.
    localparam int LIN_BITS    = COORD_BITS + PITCH_BITS + 2;
    localparam int PADDR_BITS  = 3;
    localparam int OPQ_DEPTH   = 2;

    localparam logic [1:0] KIND_SET  = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_SPAN = 2'd2;
    localparam logic [1:0] KIND_BAR  = 2'd3;

    localparam logic [7:0] MASK_LEFT  = 8'h80;
    localparam logic [7:0] MASK_ALL   = 8'hFF;
    localparam logic [2:0] BIT_LAST   = 3'd7;

    typedef logic [1:0]            t_kind;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [PITCH_BITS-1:0] t_pitch;
    typedef logic [LIN_BITS-1:0]   t_lin;

    // One decoded command: a run of byte read-modify-writes, or a masked byte read.
    typedef struct packed {
        t_lin       base;
        t_pitch     step;
        t_coord     count;
        logic [7:0] mid_mask;
        logic [7:0] first_mask;
        logic [7:0] last_mask;
        logic       fill;
        logic       is_read;
    } t_op;

    typedef struct packed {
        logic read_pixel;
        logic out_of_range;
    } t_result;

endpackage

`default_nettype wire

[rtl/mono_framebuffer_draw_engine_unit.sv]
// Each in-store byte of a command takes a read state, then a modify-write state; a byte beyond
// the store takes only the read state and sets the out-of-range flag.
// The byte engine runs one command at a time in its read-modify-write loop; the front end
// and a 2-deep command queue take new commands and overlap decode with the previous command.
// Reset (synchronous, active low): the 16384-byte store is swept to zero, one byte a cycle,
// with full held high; line_pitch returns to 40 and can be written during the sweep.
`default_nettype none

module mono_framebuffer_draw_engine_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [fbd_pkg::PADDR_BITS-1:0] paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire                          push,
    output logic                         full,
    input  wire fbd_pkg::t_kind          i_kind,
    input  wire fbd_pkg::t_coord         i_x_pos,
    input  wire fbd_pkg::t_coord         i_y_pos,
    input  wire fbd_pkg::t_coord         i_length,
    input  wire                          i_color,
    output logic                         empty,
    input  wire                          pop,
    output logic                         o_read_pixel,
    output logic                         o_out_of_range
);
    import fbd_pkg::*;

    t_pitch  r_pitch;
    logic    w_clearing;
    logic    w_fr_valid;
    t_op     w_fr_op;
    logic    w_q_full;
    logic    w_q_empty;
    logic    w_q_pop;
    t_op     w_q_op;
    logic    w_res_valid;
    t_result w_res;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : 32'(r_pitch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= PITCH_BITS'(PITCH_RESET);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_pitch <= pwdata[PITCH_BITS-1:0];
        end
    end

    fbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (w_clearing),
        .i_push     (push),
        .i_kind     (i_kind),
        .i_x_pos    (i_x_pos),
        .i_y_pos    (i_y_pos),
        .i_length   (i_length),
        .i_color    (i_color),
        .i_pitch    (r_pitch),
        .o_full     (full),
        .o_op_valid (w_fr_valid),
        .o_op       (w_fr_op),
        .i_op_full  (w_q_full)
    );

    fbd_op_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_valid),
        .i_op    (w_fr_op),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_op    (w_q_op)
    );

    fbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_empty  (w_q_empty),
        .i_op        (w_q_op),
        .o_op_pop    (w_q_pop),
        .o_clearing  (w_clearing),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_pop   (pop)
    );

    assign empty          = !w_res_valid;
    assign o_read_pixel   = w_res.read_pixel;
    assign o_out_of_range = w_res.out_of_range;

endmodule

`default_nettype wire

[rtl/fbd_front.sv]
// Command front end: registers one command, forms its start address and masks.
// Depends on fbd_pkg.
`default_nettype none

module fbd_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_hold,
    input  wire                  i_push,
    input  wire fbd_pkg::t_kind  i_kind,
    input  wire fbd_pkg::t_coord i_x_pos,
    input  wire fbd_pkg::t_coord i_y_pos,
    input  wire fbd_pkg::t_coord i_length,
    input  wire                  i_color,
    input  wire fbd_pkg::t_pitch i_pitch,
    output logic                 o_full,
    output logic                 o_op_valid,
    output fbd_pkg::t_op         o_op,
    input  wire                  i_op_full
);
    import fbd_pkg::*;

    logic       r_valid;
    t_kind      r_kind;
    t_coord     r_x;
    t_coord     r_y;
    t_coord     r_len;
    logic       r_color;
    t_pitch     r_pitch;

    logic                             w_accept;
    logic [COORD_BITS+PITCH_BITS-1:0] w_prod;
    logic [COORD_BITS:0]              w_last_px;
    logic [COORD_BITS-3:0]            w_span_bytes;
    logic [2:0]                       w_bit;
    logic [7:0]                       w_pmask;

    assign o_full   = i_hold || (r_valid && i_op_full);
    assign w_accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_op_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_x     <= i_x_pos;
            r_y     <= i_y_pos;
            r_len   <= i_length;
            r_color <= i_color;
            r_pitch <= i_pitch;
        end
    end

    assign w_prod       = (COORD_BITS+PITCH_BITS)'(r_y) * (COORD_BITS+PITCH_BITS)'(r_pitch);
    assign w_bit        = r_x[2:0];
    assign w_pmask      = MASK_LEFT >> w_bit;
    assign w_last_px    = {1'b0, r_x} + {1'b0, r_len} - (COORD_BITS+1)'(1);
    assign w_span_bytes = w_last_px[COORD_BITS:3] - {1'b0, r_x[COORD_BITS-1:3]}
                          + (COORD_BITS-2)'(1);

    always_comb begin
        o_op_valid       = r_valid;
        o_op.base        = LIN_BITS'(w_prod) + LIN_BITS'(r_x[COORD_BITS-1:3]);
        o_op.step        = r_pitch;
        o_op.count       = COORD_BITS'(1);
        o_op.mid_mask    = w_pmask;
        o_op.first_mask  = w_pmask;
        o_op.last_mask   = w_pmask;
        o_op.fill        = r_color;
        o_op.is_read     = 1'b0;
        case (r_kind)
            KIND_SET: begin
            end
            KIND_READ: begin
                o_op.is_read = 1'b1;
            end
            KIND_SPAN: begin
                o_op.step       = PITCH_BITS'(1);
                o_op.count      = (r_len == '0) ? '0 : COORD_BITS'(w_span_bytes);
                o_op.mid_mask   = MASK_ALL;
                o_op.first_mask = MASK_ALL >> w_bit;
                o_op.last_mask  = MASK_ALL << (BIT_LAST - w_last_px[2:0]);
            end
            KIND_BAR: begin
                o_op.count = r_len;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/fbd_op_queue.sv]
// Short queue of decoded commands between the front end and the byte engine.
// Depends on fbd_pkg.
`default_nettype none

module fbd_op_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire fbd_pkg::t_op i_op,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_empty,
    output fbd_pkg::t_op   o_op
);
    import fbd_pkg::*;

    localparam int PTR_BITS = $clog2(OPQ_DEPTH);

    t_op                 r_slot [OPQ_DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [PTR_BITS:0]   r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == (PTR_BITS+1)'(OPQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_BITS'(OPQ_DEPTH-1)) ? '0 : r_wr + PTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_BITS'(OPQ_DEPTH-1)) ? '0 : r_rd + PTR_BITS'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (PTR_BITS+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (PTR_BITS+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_op;
        end
    end

endmodule

`default_nettype wire

[rtl/fbd_back.sv]
// Byte engine: owns the frame store, clears it after reset and runs masked
// read-modify-writes for each draw command, or a masked read for a read command. Depends on fbd_pkg.
`default_nettype none

module fbd_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_op_empty,
    input  wire fbd_pkg::t_op i_op,
    output logic             o_op_pop,
    output logic             o_clearing,
    output logic             o_res_valid,
    output fbd_pkg::t_result o_res,
    input  wire              i_res_pop
);
    import fbd_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [7:0] r_store [STORE_BYTES];

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [ADDR_BITS-1:0] r_clr_addr;
    t_lin                 r_addr;
    t_lin                 n_addr;
    t_pitch               r_step;
    t_coord               r_left;
    t_coord               n_left;
    logic                 r_first;
    logic                 n_first;
    logic [7:0]           r_mid;
    logic [7:0]           r_fmask;
    logic [7:0]           r_lmask;
    logic                 r_fill;
    logic                 r_read;
    logic                 r_oor;
    logic                 n_oor;
    logic                 r_rd;
    logic                 n_rd;
    logic [7:0]           r_rdata;
    logic                 r_res_valid;
    t_result              r_res;

    logic                 w_beyond;
    logic                 w_adv;
    logic                 w_last;
    logic [7:0]           w_mask;
    logic                 w_we;
    logic [ADDR_BITS-1:0] w_waddr;
    logic [7:0]           w_wdata;
    logic                 w_res_load;

    assign w_beyond = (r_addr >= LIN_BITS'(STORE_BYTES));
    assign w_last   = (r_left == COORD_BITS'(1));
    assign w_mask   = r_mid & (r_first ? r_fmask : MASK_ALL) & (w_last ? r_lmask : MASK_ALL);
    assign w_adv    = ((r_state == S_READ) && w_beyond) || (r_state == S_WRITE);
    assign o_op_pop = (r_state == S_IDLE) && !i_op_empty;
    assign w_res_load = (r_state == S_DONE) && (!r_res_valid || i_res_pop);

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Store write port: the clearing sweep, or the modify half of a byte update.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr[ADDR_BITS-1:0];
        w_wdata = (r_rdata & ~w_mask) | ({8{r_fill}} & w_mask);
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_WRITE: begin
                w_we = !r_read;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_rdata <= r_store[r_addr[ADDR_BITS-1:0]];
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_left  = r_left;
        n_first = r_first;
        n_oor   = r_oor;
        n_rd    = r_rd;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_BITS'(STORE_BYTES-1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_op_empty) begin
                    n_addr  = i_op.base;
                    n_left  = i_op.count;
                    n_first = 1'b1;
                    n_oor   = 1'b0;
                    n_rd    = 1'b0;
                    n_state = (i_op.count == '0) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                if (w_beyond) begin
                    n_oor = 1'b1;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (r_read) begin
                    n_rd = |(r_rdata & w_mask);
                end
            end
            S_DONE: begin
                if (w_res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_adv) begin
            n_addr  = r_addr + LIN_BITS'(r_step);
            n_left  = r_left - COORD_BITS'(1);
            n_first = 1'b0;
            n_state = w_last ? S_DONE : S_READ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
            end
            if (w_res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_left  <= n_left;
        r_first <= n_first;
        r_oor   <= n_oor;
        r_rd    <= n_rd;
        if (o_op_pop) begin
            r_step  <= i_op.step;
            r_mid   <= i_op.mid_mask;
            r_fmask <= i_op.first_mask;
            r_lmask <= i_op.last_mask;
            r_fill  <= i_op.fill;
            r_read  <= i_op.is_read;
        end
        if (w_res_load) begin
            r_res.read_pixel   <= r_rd;
            r_res.out_of_range <= r_oor;
        end
    end

endmodule

`default_nettype wire

[tb/tb_mono_framebuffer_draw_engine_unit.sv]
// Self-checking testbench for mono_framebuffer_draw_engine_unit: a shadow framebuffer
// predicts every command's read pixel and out-of-range flag under several line pitches.
// Depends on rtl/fbd_pkg.sv and rtl/mono_framebuffer_draw_engine_unit.sv.

module tb_mono_framebuffer_draw_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fbd_pkg::*;

    localparam logic [PADDR_BITS-1:0] PITCH_ADDR = '0;

    typedef struct {
        t_kind  kind;
        t_coord x_pos;
        t_coord y_pos;
        t_coord length;
        logic   color;
    } t_draw_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  push = 1'b0;
    logic                  full;
    t_kind                 i_kind = KIND_SET;
    t_coord                i_x_pos = '0;
    t_coord                i_y_pos = '0;
    t_coord                i_length = '0;
    logic                  i_color = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_read_pixel;
    logic                  o_out_of_range;

    // shadow copy of the store and of line_pitch
    bit [7:0]     shadow_fb [STORE_BYTES];
    t_pitch       shadow_pitch = t_pitch'(PITCH_RESET);

    t_draw_cmd    cmd_q[$];
    t_draw_cmd    cur_cmd;
    t_result      status_q[$];
    t_result      exp_status;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           calm = 1'b0;
    int           err_cnt = 0;
    int           result_cnt = 0;
    longint       cycle_cnt = 0;
    longint       budget = 0;
    int unsigned  win_x = 0;
    int unsigned  win_y = 0;

    mono_framebuffer_draw_engine_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_length       (i_length),
        .i_color        (i_color),
        .empty          (empty),
        .pop            (pop),
        .o_read_pixel   (o_read_pixel),
        .o_out_of_range (o_out_of_range)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, result_cnt, msg);
        err_cnt++;
    endtask

    // Masked plain-copy write; returns 1 when the byte lies beyond the store.
    function automatic bit paint_byte(longint addr, logic [7:0] mask, logic [7:0] paint);
        if (addr >= STORE_BYTES)
            return 1'b1;
        shadow_fb[addr] = (shadow_fb[addr] & ~mask) | (paint & mask);
        return 1'b0;
    endfunction

    function automatic t_result render_cmd(t_draw_cmd c);
        t_result    res;
        longint     base;
        longint     last_px;
        longint     first_b;
        longint     last_b;
        longint     b;
        int         lo;
        int         hi;
        logic [7:0] pmask;
        logic [7:0] mask;
        logic [7:0] paint;
        res = '0;
        paint = c.color ? MASK_ALL : 8'h00;
        pmask = MASK_LEFT >> c.x_pos[2:0];
        base = longint'(c.y_pos) * longint'(shadow_pitch) + longint'(c.x_pos >> 3);
        case (c.kind)
            KIND_SET: begin
                res.out_of_range = paint_byte(base, pmask, paint);
            end
            KIND_READ: begin
                if (base >= STORE_BYTES)
                    res.out_of_range = 1'b1;
                else
                    res.read_pixel = shadow_fb[base][BIT_LAST - c.x_pos[2:0]];
            end
            KIND_SPAN: begin
                if (c.length != 0) begin
                    last_px = longint'(c.x_pos) + longint'(c.length) - 1;
                    first_b = longint'(c.x_pos >> 3);
                    last_b = last_px >> 3;
                    for (b = first_b; b <= last_b; b++) begin
                        lo = (b == first_b) ? int'(c.x_pos[2:0]) : 0;
                        hi = (b == last_b) ? int'(last_px & 7) : 7;
                        mask = (MASK_ALL >> lo) & (MASK_ALL << (7 - hi));
                        if (paint_byte(base + b - first_b, mask, paint))
                            res.out_of_range = 1'b1;
                    end
                end
            end
            default: begin
                for (b = 0; b < longint'(c.length); b++) begin
                    if (paint_byte(base + b * longint'(shadow_pitch), pmask, paint))
                        res.out_of_range = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_coord extreme_coord();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return 11'd1;
            2: return 11'd7;
            3: return 11'd8;
            4: return 11'd2040;
            default: return '1;
        endcase
    endfunction

    function automatic t_draw_cmd make_cmd();
        t_draw_cmd c;
        int        sel;
        sel = $urandom_range(99, 0);
        if (sel < 25)
            c.kind = KIND_SET;
        else if (sel < 60)
            c.kind = KIND_READ;
        else if (sel < 80)
            c.kind = KIND_SPAN;
        else
            c.kind = KIND_BAR;
        // most commands land in a small window so reads see earlier writes
        sel = $urandom_range(99, 0);
        if (sel < 70) begin
            c.x_pos = t_coord'(win_x + $urandom_range(127, 0));
            c.y_pos = t_coord'(win_y + $urandom_range(15, 0));
        end else if (sel < 88) begin
            c.x_pos = t_coord'($urandom);
            c.y_pos = t_coord'($urandom);
        end else begin
            c.x_pos = extreme_coord();
            c.y_pos = extreme_coord();
        end
        // long bars cost a read and a write per line, so keep them rare
        sel = $urandom_range(99, 0);
        if (sel < 75)
            c.length = t_coord'($urandom_range(24, 0));
        else if (sel < 95)
            c.length = t_coord'($urandom_range(255, 0));
        else if (sel < 98)
            c.length = t_coord'($urandom);
        else
            c.length = extreme_coord();
        c.color = 1'($urandom);
        return c;
    endfunction

    task automatic queue_cmd(input t_kind kind, input t_coord x, input t_coord y,
                             input t_coord len, input logic color);
        t_draw_cmd c;
        longint    nbytes;
        c.kind = kind;
        c.x_pos = x;
        c.y_pos = y;
        c.length = len;
        c.color = color;
        if (kind == KIND_SPAN)
            nbytes = longint'(len) / 8 + 2;
        else if (kind == KIND_BAR)
            nbytes = longint'(len) + 1;
        else
            nbytes = 1;
        budget += 2 * nbytes + 30;
        cmd_q.push_back(c);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (cmd_q.size() != 0 || push || status_q.size() != 0);
    endtask

    task automatic write_pitch(input int unsigned val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PITCH_ADDR;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_pitch = t_pitch'(val);
        @(negedge i_clk);
    endtask

    // command driver: predicts each transfer as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            gap_left <= 0;
        end else begin
            if (push && !full)
                status_q.push_back(render_cmd(cur_cmd));
            if (!push || !full) begin
                if (gap_left != 0) begin
                    push <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (cmd_q.size() != 0) begin
                    cur_cmd = cmd_q.pop_front();
                    i_kind <= cur_cmd.kind;
                    i_x_pos <= cur_cmd.x_pos;
                    i_y_pos <= cur_cmd.y_pos;
                    i_length <= cur_cmd.length;
                    i_color <= cur_cmd.color;
                    push <= 1'b1;
                    if (!calm && $urandom_range(5, 0) == 0)
                        gap_left <= $urandom_range(7, 1);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left <= 0;
        end else begin
            if (pop && !empty) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    exp_status = status_q.pop_front();
                    if (o_read_pixel !== exp_status.read_pixel)
                        report_mismatch($sformatf("read_pixel got %b want %b",
                                                  o_read_pixel, exp_status.read_pixel));
                    if (o_out_of_range !== exp_status.out_of_range)
                        report_mismatch($sformatf("out_of_range got %b want %b",
                                                  o_out_of_range, exp_status.out_of_range));
                end
                result_cnt++;
            end
            if (stall_left != 0) begin
                pop <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!calm && $urandom_range(7, 0) == 0) begin
                pop <= 1'b0;
                stall_left <= $urandom_range(6, 0);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog; the constant covers the store sweep after reset
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 40000 + 4 * budget) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned pitch;
        int unsigned rows;
        int          n_items;
        t_draw_cmd   c;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, at the reset pitch of 40
        queue_cmd(KIND_SET,  11'd0,    11'd0,    11'd0,    1'b1);
        queue_cmd(KIND_READ, 11'd0,    11'd0,    11'd0,    1'b0);
        queue_cmd(KIND_SET,  11'd7,    11'd0,    11'd0,    1'b1);
        queue_cmd(KIND_READ, 11'd7,    11'd0,    11'd0,    1'b1);
        queue_cmd(KIND_READ, 11'd6,    11'd0,    11'd0,    1'b0);
        queue_cmd(KIND_SPAN, 11'd3,    11'd1,    11'd0,    1'b1);   // zero length
        queue_cmd(KIND_SPAN, 11'd3,    11'd1,    11'd2,    1'b1);   // inside one byte
        queue_cmd(KIND_SPAN, 11'd5,    11'd2,    11'd20,   1'b1);   // both edge masks
        queue_cmd(KIND_READ, 11'd4,    11'd2,    11'd0,    1'b0);
        queue_cmd(KIND_READ, 11'd24,   11'd2,    11'd0,    1'b0);
        queue_cmd(KIND_READ, 11'd25,   11'd2,    11'd0,    1'b0);
        queue_cmd(KIND_SPAN, 11'd316,  11'd3,    11'd10,   1'b1);   // runs into next line
        queue_cmd(KIND_READ, 11'd2,    11'd4,    11'd0,    1'b0);
        queue_cmd(KIND_BAR,  11'd9,    11'd10,   11'd5,    1'b1);
        queue_cmd(KIND_BAR,  11'd9,    11'd11,   11'd2,    1'b0);
        queue_cmd(KIND_READ, 11'd9,    11'd14,   11'd0,    1'b0);
        queue_cmd(KIND_SET,  11'd400,  11'd0,    11'd0,    1'b1);   // column past the pitch
        queue_cmd(KIND_READ, 11'd80,   11'd1,    11'd0,    1'b0);
        queue_cmd(KIND_BAR,  11'd0,    11'd400,  11'd20,   1'b1);   // bar off the store end
        queue_cmd(KIND_SPAN, 11'd0,    11'd409,  11'd2047, 1'b1);   // span off the store end
        queue_cmd(KIND_SET,  11'd2047, 11'd2047, 11'd0,    1'b1);
        queue_cmd(KIND_READ, 11'd2047, 11'd2047, 11'd2047, 1'b1);
        queue_cmd(KIND_BAR,  11'd2047, 11'd0,    11'd2047, 1'b0);
        queue_cmd(KIND_SET,  11'd0,    11'd0,    11'd0,    1'b0);
        queue_cmd(KIND_READ, 11'd0,    11'd0,    11'd0,    1'b0);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin pitch = 1;                        n_items = 130; end
                1: begin pitch = 2048;                     n_items = 90;  end
                2: begin pitch = 4095;                     n_items = 70;  end
                3: begin pitch = 0;                        n_items = 90;  end
                4: begin pitch = $urandom_range(300, 2);   n_items = 170; end
                default: begin pitch = $urandom_range(64, 8); n_items = 180; end
            endcase
            wait_idle();
            calm = (p == 5);
            write_pitch(pitch);
            rows = (pitch == 0) ? 2048 : STORE_BYTES / pitch;
            if (rows > 2047)
                rows = 2047;
            win_y = (rows > 16) ? $urandom_range(rows - 16, 0) : 0;
            win_x = $urandom_range(255, 0);
            for (int i = 0; i < n_items; i++) begin
                c = make_cmd();
                queue_cmd(c.kind, c.x_pos, c.y_pos, c.length, c.color);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
rtl/fbd_pkg.sv
rtl/fbd_front.sv
rtl/fbd_op_queue.sv
rtl/fbd_back.sv
rtl/mono_framebuffer_draw_engine_unit.sv
tb/tb_mono_framebuffer_draw_engine_unit.sv
